FILE: rtl/core/mud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mud_pkg;

  typedef struct packed {
    logic signed [15:0] current_sample;
    logic [31:0]        sample_time;
  } mud_in_t;

  typedef struct packed {
    logic        airborne;
    logic [31:0] episode_start;
    logic [31:0] episode_count;
    logic [14:0] lowest_current;
  } mud_out_t;

  // Register map, indexed by paddr[2].
  localparam logic REG_VAR_LIMIT = 1'b0;
  localparam logic REG_BASELINE  = 1'b1;

  localparam int CFG_AW = 3;

  localparam logic [29:0] VAR_LIMIT_RST = 30'd52429;
  localparam logic [14:0] BASELINE_RST  = 15'd1024;
  localparam logic [15:0] MIN_SEEN_RST  = 16'd32767;

  // Low-current test: mag * CUR_SCALE < baseline * BASE_SCALE.
  localparam int          LOW_W      = 20;
  localparam logic [19:0] CUR_SCALE  = 20'd10;
  localparam logic [19:0] BASE_SCALE = 20'd3;

endpackage

`default_nettype wire

FILE: rtl/core/mud_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mud_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/motor_unload_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Motor unload detector. Each input beat carries a signed Q5.10 current sample and a
// millisecond timestamp; each one yields exactly one result beat with the unloaded flag,
// the start time and count of unloaded episodes, and the lowest current seen while
// unloaded. A sample holds the block from the write state through scan, M1 to M4 and
// compare. One multiplier serves every product but the low-current test's constant
// scaling; it squares the window slots one per cycle as they are read back from the
// window RAM, then forms the spread, count squared and the limit product in turn.
// in_ready is high only in the idle state. A finished result sits in an output register,
// so the next sample is taken while it waits.
// Registers: variance_limit at address 0, the on-ground baseline at address 4; write
// them only while the block is idle.
module motor_unload_detector_top
  import mud_pkg::*;
#(
  parameter int WINDOW_LEN = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mud_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mud_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int AW      = $clog2(WINDOW_LEN);
  localparam int IW      = $clog2(WINDOW_LEN + 2);
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int CSQ_W   = 2 * CNT_W;
  localparam int SUM_W   = 16 + CNT_W;
  localparam int SUMSQ_W = 31 + CNT_W;
  localparam int A_W     = SUMSQ_W;
  localparam int B_W     = SUM_W;
  localparam int P_W     = A_W + B_W;
  localparam int SPR_W   = A_W + CNT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_M1    = 3'd3;
  localparam logic [2:0] ST_M2    = 3'd4;
  localparam logic [2:0] ST_M3    = 3'd5;
  localparam logic [2:0] ST_M4    = 3'd6;
  localparam logic [2:0] ST_CMP   = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [29:0]           var_limit_r;
  logic [14:0]           baseline_r;
  logic [15:0]           mag_r;
  logic [31:0]           time_r;
  logic [AW-1:0]         slot_r;
  logic [WINDOW_LEN-1:0] vld_r;
  logic [IW-1:0]         idx_r;
  logic                  rd_pend_r, sq_pend_r, rd_vld_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUMSQ_W-1:0]    sumsq_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [P_W-1:0]        prod_r;
  logic [P_W-1:0]        prod_nxt;
  logic [SPR_W-1:0]      tmp_r;
  logic [SPR_W-1:0]      held_spread_r;
  logic [CSQ_W-1:0]      held_csq_r;
  logic                  flag_r;
  logic [31:0]           start_r, total_r;
  logic [15:0]           min_r;
  logic                  out_valid_r;
  mud_out_t              out_data_r;

  logic [15:0]           rdata;
  logic [15:0]           rd_val;
  logic                  issue;
  logic [A_W-1:0]        op_a;
  logic [B_W-1:0]        op_b;
  logic [CSQ_W-1:0]      csq_sel;
  logic                  multi;
  logic                  low_cur, var_hit, detected, out_free;
  logic                  cfg_wr;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_BASELINE) begin
      prdata = {17'd0, baseline_r};
    end else begin
      prdata = {2'd0, var_limit_r};
    end
  end

  assign issue    = (state_r == ST_SCAN) && (idx_r < IW'(WINDOW_LEN));
  assign rd_val   = rd_vld_r ? rdata : 16'd0;
  assign multi    = (cnt_r > CNT_W'(1));
  assign out_free = !out_valid_r || out_ready;

  mud_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (state_r == ST_WRITE),
    .waddr (slot_r),
    .wdata (mag_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // Count squared is fresh in prod_r during M4; by CMP it has landed in held_csq_r.
  assign csq_sel = (state_r == ST_M4 && multi) ? prod_r[CSQ_W-1:0] : held_csq_r;

  always_comb begin
    op_a = A_W'(rd_val);
    op_b = B_W'(rd_val);
    case (state_r) inside
      ST_M1: begin
        op_a = sumsq_r;
        op_b = B_W'(cnt_r);
      end
      ST_M2: begin
        op_a = A_W'(sum_r);
        op_b = sum_r;
      end
      ST_M3: begin
        op_a = A_W'(cnt_r);
        op_b = B_W'(cnt_r);
      end
      ST_M4, ST_CMP: begin
        op_a = A_W'(var_limit_r);
        op_b = B_W'(csq_sel);
      end
      default: begin
        op_a = A_W'(rd_val);
        op_b = B_W'(rd_val);
      end
    endcase
  end

  // The product is formed at its full width before it is registered.
  assign prod_nxt = op_a * op_b;

  assign low_cur  = (LOW_W'(mag_r) * CUR_SCALE) < (LOW_W'(baseline_r) * BASE_SCALE);
  assign var_hit  = P_W'(held_spread_r) < prod_r;
  assign detected = low_cur || var_hit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_SCAN;
      ST_SCAN:  if (idx_r == IW'(WINDOW_LEN + 1)) state_nxt = ST_M1;
      ST_M1:    state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_M4;
      ST_M4:    state_nxt = ST_CMP;
      ST_CMP:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;

    if (state_r == ST_IDLE && in_valid) begin
      mag_r  <= in_data.current_sample[15] ? 16'(~in_data.current_sample + 16'sd1)
                                           : in_data.current_sample;
      time_r <= in_data.sample_time;
    end

    if (state_r == ST_WRITE) begin
      sum_r   <= '0;
      sumsq_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (rd_pend_r) begin
        sum_r <= sum_r + SUM_W'(rd_val);
        if (rd_val != 16'd0) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (sq_pend_r) begin
        sumsq_r <= sumsq_r + prod_r[SUMSQ_W-1:0];
      end
    end

    if (issue) begin
      rd_vld_r <= vld_r[idx_r[AW-1:0]];
    end

    if (state_r == ST_M2) begin
      tmp_r <= prod_r[SPR_W-1:0];
    end

    if (state_r == ST_CMP && out_free) begin
      out_data_r.airborne       <= detected;
      out_data_r.episode_start  <= (detected && !flag_r) ? time_r : start_r;
      out_data_r.episode_count  <= (detected && !flag_r) ? total_r + 32'd1 : total_r;
      out_data_r.lowest_current <= (detected && mag_r < min_r) ? mag_r[14:0] : min_r[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      var_limit_r   <= VAR_LIMIT_RST;
      baseline_r    <= BASELINE_RST;
      slot_r        <= '0;
      vld_r         <= '0;
      idx_r         <= '0;
      rd_pend_r     <= 1'b0;
      sq_pend_r     <= 1'b0;
      held_spread_r <= '0;
      held_csq_r    <= CSQ_W'(1);
      flag_r        <= 1'b0;
      start_r       <= '0;
      total_r       <= '0;
      min_r         <= MIN_SEEN_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= issue;
      sq_pend_r <= rd_pend_r;

      if (cfg_wr) begin
        if (paddr[2] == REG_VAR_LIMIT) begin
          var_limit_r <= pwdata[29:0];
        end else begin
          baseline_r <= pwdata[14:0];
        end
      end

      if (state_r == ST_WRITE) begin
        vld_r[slot_r] <= 1'b1;
        slot_r        <= (slot_r == AW'(WINDOW_LEN - 1)) ? '0 : slot_r + AW'(1);
        idx_r         <= '0;
      end else if (state_r == ST_SCAN) begin
        idx_r <= idx_r + IW'(1);
      end

      // With fewer than two nonzero slots the previous spread and count squared stay.
      if (state_r == ST_M3 && multi) begin
        held_spread_r <= tmp_r - prod_r[SPR_W-1:0];
      end
      if (state_r == ST_M4 && multi) begin
        held_csq_r <= prod_r[CSQ_W-1:0];
      end

      if (state_r == ST_CMP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == ST_CMP && out_free) begin
        flag_r <= detected;
        if (detected && !flag_r) begin
          start_r <= time_r;
          total_r <= total_r + 32'd1;
        end
        if (detected && mag_r < min_r) begin
          min_r <= mag_r;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mud_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mud_checker
  import mud_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire mud_out_t out_data
);

  // A result beat that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The block does not take a new sample right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // No result can appear right after a sample is taken.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind motor_unload_detector_top mud_checker u_mud_checker (.*);

`default_nettype wire
